// ----- hw/rtl/address_blocklist_table_defines.svh -----
// Assertion macros for the address blocklist table.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ADDRESS_BLOCKLIST_TABLE_DEFINES_SVH
`define ADDRESS_BLOCKLIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define ABT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blocklist table: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ABT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blocklist table: next-cycle check failed");

`else

`define ABT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ABT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/abt_pkg.sv -----
// Shared types and constants for the address blocklist table.
// No dependencies; used by address_blocklist_table.
package abt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int ADDR_W              = 32;
   localparam int STAMP_W             = 32;
   localparam int COUNT_OUT_W         = 7;

   // Request type codes
   localparam logic [1:0] REQ_CHECK  = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   // Reserved address that an add ignores (zero is the other one)
   localparam logic [ADDR_W-1:0] ADDR_NONE = '1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [ADDR_W-1:0]  address;
      logic [STAMP_W-1:0] timestamp;
   } req_word_type;

   typedef struct packed {
      logic                   hit;
      logic                   evicted;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_word_type;

endpackage

// ----- hw/rtl/address_blocklist_table.sv -----
// Sequence: an accepted request scans the held entries one by one and is then decided; a delete
// or an eviction shifts the entries after the removed position down, an add of a new address
// then appends, and rsp_valid rises once the output register is free.
// Throughput: one request at a time, set by the single-port scan of the table.
// Reset (synchronous, active high) empties the table and clears all control
// state; table memories are not cleared, entries beyond the count are never read.
`include "address_blocklist_table_defines.svh"

module address_blocklist_table #(
   parameter int TABLE_DEPTH = abt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  abt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output abt_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_SHIFT  = 6'b001000,
      ST_APPEND = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   abt_pkg::req_word_type         req_ff, req_in;
   logic [CNT_W-1:0]              cursor_ff, cursor_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]              rd_pos_ff, rd_pos_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              match_ff, match_in;
   logic [abt_pkg::STAMP_W-1:0]   old_stamp_ff, old_stamp_in;
   logic [IDX_W-1:0]              old_pos_ff, old_pos_in;
   logic                          hit_ff, hit_in;
   logic                          evict_ff, evict_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   abt_pkg::rsp_word_type         rsp_ff, rsp_in;

   // Table storage: one write and one registered read per cycle
   logic [abt_pkg::ADDR_W-1:0]    addr_mem  [TABLE_DEPTH];
   logic [abt_pkg::STAMP_W-1:0]   stamp_mem [TABLE_DEPTH];
   logic [abt_pkg::ADDR_W-1:0]    addr_rd_ff;
   logic [abt_pkg::STAMP_W-1:0]   stamp_rd_ff;
   logic [IDX_W-1:0]              rd_idx;
   logic                          mem_we;
   logic [IDX_W-1:0]              wr_idx;
   logic [abt_pkg::ADDR_W-1:0]    wr_addr;
   logic [abt_pkg::STAMP_W-1:0]   wr_stamp;
   logic                          reserved;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign reserved  = (req_ff.address == '0) || (req_ff.address == abt_pkg::ADDR_NONE);

   // Sequencer: scan, decide, shift down, append, deliver
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      rd_valid_in  = 1'b0;
      rd_pos_in    = rd_pos_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      old_stamp_in = old_stamp_ff;
      old_pos_in   = old_pos_ff;
      hit_in       = hit_ff;
      evict_in     = evict_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_idx       = cursor_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      wr_idx       = rd_pos_ff - IDX_W'(1);
      wr_addr      = addr_rd_ff;
      wr_stamp     = stamp_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_word;
               cursor_in = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue the next read
            if (cursor_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_pos_in   = cursor_ff[IDX_W-1:0];
               cursor_in   = cursor_ff + CNT_W'(1);
            end
            // match the first hit and track the oldest stamp
            if (rd_valid_ff) begin
               if (!found_ff && addr_rd_ff == req_ff.address) begin
                  found_in = 1'b1;
                  match_in = rd_pos_ff;
               end
               if (rd_pos_ff == '0 || stamp_rd_ff < old_stamp_ff) begin
                  old_stamp_in = stamp_rd_ff;
                  old_pos_in   = rd_pos_ff;
               end
            end
            if (cursor_ff >= count_ff && !rd_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            hit_in   = 1'b0;
            evict_in = 1'b0;
            state_in = ST_DONE;
            unique case (req_ff.req_type)
               abt_pkg::REQ_CHECK: begin
                  hit_in = found_ff;
               end
               abt_pkg::REQ_ADD: begin
                  if (!reserved) begin
                     if (found_ff) begin
                        hit_in = 1'b1;
                     end else if (count_ff == DEPTH_C) begin
                        evict_in  = 1'b1;
                        cursor_in = CNT_W'(old_pos_ff) + CNT_W'(1);
                        state_in  = ST_SHIFT;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
               end
               abt_pkg::REQ_DELETE: begin
                  if (found_ff) begin
                     hit_in    = 1'b1;
                     cursor_in = CNT_W'(match_ff) + CNT_W'(1);
                     state_in  = ST_SHIFT;
                  end
               end
               default: begin
                  hit_in = 1'b0;
               end
            endcase
         end

         ST_SHIFT: begin
            // read entry k+1, write it to k on the following cycle
            if (cursor_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_pos_in   = cursor_ff[IDX_W-1:0];
               cursor_in   = cursor_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               mem_we = 1'b1;
            end
            if (cursor_ff >= count_ff && !rd_valid_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = evict_ff ? ST_APPEND : ST_DONE;
            end
         end

         ST_APPEND: begin
            mem_we   = 1'b1;
            wr_idx   = count_ff[IDX_W-1:0];
            wr_addr  = req_ff.address;
            wr_stamp = req_ff.timestamp;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // load the output word once the previous one has gone
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = hit_ff;
               rsp_in.evicted     = evict_ff;
               rsp_in.entry_count = abt_pkg::COUNT_OUT_W'(count_ff);
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cursor_ff    <= cursor_in;
      rd_pos_ff    <= rd_pos_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      old_stamp_ff <= old_stamp_in;
      old_pos_ff   <= old_pos_in;
      hit_ff       <= hit_in;
      evict_ff     <= evict_in;
      rsp_ff       <= rsp_in;
   end

   // Table memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         addr_mem[wr_idx]  <= wr_addr;
         stamp_mem[wr_idx] <= wr_stamp;
      end
      addr_rd_ff  <= addr_mem[rd_idx];
      stamp_rd_ff <= stamp_mem[rd_idx];
   end

   `ABT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `ABT_ASSERT_IMP(a_write_state, clock, reset, mem_we, state_ff == ST_SHIFT || state_ff == ST_APPEND)
   `ABT_ASSERT_NEXT(a_accept_scan, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN)
   `ABT_ASSERT_IMP(a_evict_nohit, clock, reset, rsp_valid_ff, !(rsp_ff.hit && rsp_ff.evicted))

endmodule
